FILE: rtl/sld_pkg.sv
// sld_pkg: constants, result codes and code point class tests for the
// script language detector. Depends on nothing.
package sld_pkg;

  localparam int MAX_CHARS_DEF = 4096;
  localparam int CP_W          = 16;
  localparam int LANG_W        = 3;
  localparam int TGT_W         = 3;

  localparam logic [LANG_W-1:0] LANG_OTHER    = 3'd0;
  localparam logic [LANG_W-1:0] LANG_JAPANESE = 3'd1;
  localparam logic [LANG_W-1:0] LANG_KOREAN   = 3'd2;
  localparam logic [LANG_W-1:0] LANG_RUSSIAN  = 3'd3;
  localparam logic [LANG_W-1:0] LANG_CHINESE  = 3'd4;

  localparam logic [TGT_W-1:0] TGT_LATIN   = 3'd0;
  localparam logic [TGT_W-1:0] TGT_CHINESE = 3'd1;
  localparam logic [TGT_W-1:0] TGT_JAPANESE = 3'd2;
  localparam logic [TGT_W-1:0] TGT_KOREAN  = 3'd3;
  localparam logic [TGT_W-1:0] TGT_RUSSIAN = 3'd4;

  function automatic logic in_rng(logic [CP_W-1:0] c, logic [CP_W-1:0] lo,
                                  logic [CP_W-1:0] hi);
    return (c >= lo) && (c <= hi);
  endfunction

  function automatic logic is_upper(logic [CP_W-1:0] c);
    return in_rng(c, 16'h0041, 16'h005A);
  endfunction

  function automatic logic is_lower(logic [CP_W-1:0] c);
    return in_rng(c, 16'h0061, 16'h007A);
  endfunction

  function automatic logic is_han(logic [CP_W-1:0] c);
    return in_rng(c, 16'h3400, 16'h4DBF) || in_rng(c, 16'h4E00, 16'h9FFF) ||
           in_rng(c, 16'hF900, 16'hFAFF);
  endfunction

  function automatic logic is_kana(logic [CP_W-1:0] c);
    return in_rng(c, 16'h3040, 16'h30FF) || in_rng(c, 16'h31F0, 16'h31FF);
  endfunction

  function automatic logic is_hangul(logic [CP_W-1:0] c);
    return in_rng(c, 16'hAC00, 16'hD7AF) || in_rng(c, 16'h1100, 16'h11FF);
  endfunction

  function automatic logic is_cyrillic(logic [CP_W-1:0] c);
    return in_rng(c, 16'h0400, 16'h04FF);
  endfunction

  function automatic logic is_latin_ext(logic [CP_W-1:0] c);
    return in_rng(c, 16'h00C0, 16'h024F);
  endfunction

  // digits and the path marks _ . / : \ -
  function automatic logic is_code_mark(logic [CP_W-1:0] c);
    return in_rng(c, 16'h0030, 16'h0039) || (c == 16'h005F) || (c == 16'h002E) ||
           (c == 16'h002F) || (c == 16'h003A) || (c == 16'h005C) || (c == 16'h002D);
  endfunction

endpackage

FILE: rtl/sld_in_if.sv
// sld_in_if: character stream channel, one code unit per beat.
// Depends on sld_pkg.
interface sld_in_if;
  logic                      valid;
  logic                      ready;
  logic [sld_pkg::CP_W-1:0]  code_point;
  logic                      last;

  modport source (output valid, output code_point, output last, input ready);
  modport sink (input valid, input code_point, input last, output ready);
endinterface

FILE: rtl/sld_out_if.sv
// sld_out_if: result channel, one detection result per beat.
// Depends on sld_pkg.
interface sld_out_if;
  logic                        valid;
  logic                        ready;
  logic [sld_pkg::LANG_W-1:0]  language;
  logic                        target_match;

  modport source (output valid, output language, output target_match, input ready);
  modport sink (input valid, input language, input target_match, output ready);
endinterface

FILE: rtl/script_language_detector.sv
// script_language_detector: per-text script counting and language decision.
// Depends on sld_pkg, sld_in_if and sld_out_if.
//
// channel   dir  payload                    beat
// char_in   in   code_point[15:0], last     one code unit
// result    out  language[2:0], target_match one result per text (on last)
// cfg       in   cfg_wdata[2:0]             target language, on cfg_we
//
// One code unit per cycle while no last beat waits on an occupied snapshot.
// Input register -> counter update -> snapshot of the final counts on last
// -> decision -> result register. Synchronous reset clears all counts, run
// state and the target. A stalled result holds the snapshot; non-last beats
// keep flowing until another last beat finds the snapshot still occupied.
module script_language_detector #(
  parameter int MAX_CHARS = sld_pkg::MAX_CHARS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  sld_in_if.sink                    char_in,
  sld_out_if.source                 result,
  input  logic                      cfg_we,
  input  logic [sld_pkg::TGT_W-1:0] cfg_wdata
);

  localparam int CntW = $clog2(MAX_CHARS + 1);
  localparam logic [CntW-1:0] MaxC = CntW'(MAX_CHARS);

  typedef struct packed {
    logic [CntW-1:0] kana;
    logic [CntW-1:0] hangul;
    logic [CntW-1:0] han;
    logic [CntW-1:0] cyr;
    logic [CntW-1:0] latin;
    logic [CntW-1:0] pen;
  } counts_t;

  function automatic logic [CntW-1:0] sat_inc(logic [CntW-1:0] x);
    return (x == MaxC) ? x : x + CntW'(1);
  endfunction

  // input stage
  logic                      a_valid;
  logic [sld_pkg::CP_W-1:0]  a_cp;
  logic                      a_last;
  logic                      a_fire;

  // snapshot and result stages
  logic                      b_valid;
  counts_t                   snap;
  logic                      b_take;
  logic                      b_free;
  logic                      c_valid;
  logic [sld_pkg::LANG_W-1:0] c_lang;
  logic                      c_match;

  logic [sld_pkg::TGT_W-1:0] tgt;

  // running state
  counts_t                   cnt;
  logic                      run_active;
  logic [CntW-1:0]           run_total;
  logic [1:0]                run_upper;
  logic                      run_lower;
  logic                      run_code;
  logic                      run_han_bef;
  logic                      prev_han;

  counts_t                   cnt_next;
  logic                      run_active_next;
  logic [CntW-1:0]           run_total_next;
  logic [1:0]                run_upper_next;
  logic                      run_lower_next;
  logic                      run_code_next;
  logic                      run_han_bef_next;

  logic                      up, lo, letter, han, cmark, close_run, camel, pen_hit;
  logic [CntW:0]             pen_sum;

  assign b_take       = b_valid && (!c_valid || result.ready);
  assign b_free       = !b_valid || b_take;
  assign a_fire       = a_valid && (!a_last || b_free);
  assign char_in.ready = !a_valid || a_fire;

  always_comb begin
    up     = sld_pkg::is_upper(a_cp);
    lo     = sld_pkg::is_lower(a_cp);
    letter = up || lo;
    han    = sld_pkg::is_han(a_cp);
    cmark  = sld_pkg::is_code_mark(a_cp);

    run_active_next  = run_active;
    run_total_next   = run_total;
    run_upper_next   = run_upper;
    run_lower_next   = run_lower;
    run_code_next    = run_code;
    run_han_bef_next = run_han_bef;

    if (letter) begin
      if (!run_active) begin
        run_active_next  = 1'b1;
        run_total_next   = CntW'(1);
        run_upper_next   = up ? 2'd1 : 2'd0;
        run_lower_next   = lo;
        run_code_next    = 1'b0;
        run_han_bef_next = prev_han;
      end else begin
        run_total_next = sat_inc(run_total);
        if (up && run_upper != 2'd3) begin
          run_upper_next = run_upper + 2'd1;
        end
        if (lo) begin
          run_lower_next = 1'b1;
        end
      end
    end else if (run_active && cmark) begin
      run_code_next = 1'b1;
    end

    // run ends on a plain character, or is still open at end of text
    close_run = (run_active && !letter && !cmark) || (a_last && run_active_next);
    camel     = (run_upper_next >= 2'd2) && run_lower_next;
    pen_hit   = close_run && (camel || run_code_next || run_han_bef_next || han) &&
                (run_total_next > CntW'(2));
    pen_sum   = {1'b0, cnt.pen} + {1'b0, run_total_next - CntW'(2)};
    if (close_run) begin
      run_active_next = 1'b0;
    end

    cnt_next = cnt;
    if (pen_hit) begin
      cnt_next.pen = (pen_sum > {1'b0, MaxC}) ? MaxC : pen_sum[CntW-1:0];
    end
    if (sld_pkg::is_kana(a_cp)) begin
      cnt_next.kana = sat_inc(cnt.kana);
    end else if (sld_pkg::is_hangul(a_cp)) begin
      cnt_next.hangul = sat_inc(cnt.hangul);
    end else if (han) begin
      cnt_next.han = sat_inc(cnt.han);
    end else if (sld_pkg::is_cyrillic(a_cp)) begin
      cnt_next.cyr = sat_inc(cnt.cyr);
    end else if (letter || sld_pkg::is_latin_ext(a_cp)) begin
      cnt_next.latin = sat_inc(cnt.latin);
    end
  end

  // decision on the snapshot
  logic [CntW+3:0]           kana12;
  logic [CntW+1:0]           han3;
  logic [CntW-1:0]           evid;
  logic [CntW+1:0]           cjk;
  logic [CntW+2:0]           cjk2;
  logic [CntW+2:0]           letters;
  logic                      lone_latin;
  logic [sld_pkg::LANG_W-1:0] lang_next;
  logic                      match_next;

  always_comb begin
    kana12  = {1'b0, snap.kana, 3'b000} + {2'b00, snap.kana, 2'b00};
    han3    = {1'b0, snap.han, 1'b0} + {2'b00, snap.han};
    evid    = (snap.latin > snap.pen) ? snap.latin - snap.pen : '0;
    cjk     = {2'b00, snap.han} + {2'b00, snap.kana} + {2'b00, snap.hangul};
    cjk2    = {cjk, 1'b0};
    letters = {1'b0, cjk} + {3'b000, snap.latin} + {3'b000, snap.cyr};
    lone_latin = (letters == (CntW+3)'(1)) && (snap.latin == CntW'(1));

    if (snap.kana != '0 && kana12 >= {4'b0000, snap.han}) begin
      lang_next = sld_pkg::LANG_JAPANESE;
    end else if (snap.hangul != '0) begin
      lang_next = sld_pkg::LANG_KOREAN;
    end else if (snap.cyr > snap.latin && snap.cyr >= CntW'(2)) begin
      lang_next = sld_pkg::LANG_RUSSIAN;
    end else if (snap.han >= CntW'(2) && han3 >= {2'b00, evid}) begin
      lang_next = sld_pkg::LANG_CHINESE;
    end else begin
      lang_next = sld_pkg::LANG_OTHER;
    end

    if (tgt == sld_pkg::TGT_LATIN) begin
      match_next = !(cjk != '0 && cjk2 >= {3'b000, snap.latin});
    end else if (letters == '0) begin
      match_next = 1'b1;
    end else begin
      unique case (tgt)
        sld_pkg::TGT_CHINESE:  match_next = snap.han != '0 || lone_latin;
        sld_pkg::TGT_JAPANESE: match_next = snap.kana != '0 || snap.han != '0 || lone_latin;
        sld_pkg::TGT_KOREAN:   match_next = snap.hangul != '0 || lone_latin;
        sld_pkg::TGT_RUSSIAN:  match_next = snap.cyr != '0 || lone_latin;
        default:               match_next = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid     <= 1'b0;
      b_valid     <= 1'b0;
      c_valid     <= 1'b0;
      tgt         <= sld_pkg::TGT_LATIN;
      cnt         <= '0;
      run_active  <= 1'b0;
      run_total   <= '0;
      run_upper   <= '0;
      run_lower   <= 1'b0;
      run_code    <= 1'b0;
      run_han_bef <= 1'b0;
      prev_han    <= 1'b0;
    end else begin
      if (cfg_we) begin
        tgt <= cfg_wdata;
      end
      if (char_in.ready) begin
        a_valid <= char_in.valid;
      end
      if (a_fire) begin
        if (a_last) begin
          cnt         <= '0;
          run_active  <= 1'b0;
          run_total   <= '0;
          run_upper   <= '0;
          run_lower   <= 1'b0;
          run_code    <= 1'b0;
          run_han_bef <= 1'b0;
          prev_han    <= 1'b0;
        end else begin
          cnt         <= cnt_next;
          run_active  <= run_active_next;
          run_total   <= run_total_next;
          run_upper   <= run_upper_next;
          run_lower   <= run_lower_next;
          run_code    <= run_code_next;
          run_han_bef <= run_han_bef_next;
          prev_han    <= han;
        end
      end
      if (a_fire && a_last) begin
        b_valid <= 1'b1;
      end else if (b_take) begin
        b_valid <= 1'b0;
      end
      if (b_take) begin
        c_valid <= 1'b1;
      end else if (result.ready) begin
        c_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (char_in.ready) begin
      a_cp   <= char_in.code_point;
      a_last <= char_in.last;
    end
    if (a_fire && a_last) begin
      snap <= cnt_next;
    end
    if (b_take) begin
      c_lang  <= lang_next;
      c_match <= match_next;
    end
  end

  assign result.valid        = c_valid;
  assign result.language     = c_lang;
  assign result.target_match = c_match;

`ifndef SYNTHESIS
  a_result_from_snapshot: assert property (@(posedge clk) disable iff (rst)
    $rose(c_valid) |-> $past(b_valid))
    else $error("result raised without a snapshot");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (a_fire && a_last) |=> (cnt == '0 && !run_active && !prev_han))
    else $error("state not cleared after end of text");

  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    (cnt.kana <= MaxC && cnt.han <= MaxC && cnt.latin <= MaxC &&
     cnt.pen <= MaxC && run_total <= MaxC))
    else $error("counter beyond saturation limit");

  a_stall_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (a_valid && !a_fire && !cfg_we) |=> ($stable(cnt) && $stable(run_total)))
    else $error("state changed on a held beat");
`endif

endmodule

FILE: sim/sld_script_checker.sv
`timescale 1ns / 1ps
// sld_script_checker: follows the character and result channels of the script
// language detector, predicts each text's verdict and compares it per field.
// Depends on sld_pkg, sld_in_if and sld_out_if.
module sld_script_checker #(
  parameter int MAX_CHARS = sld_pkg::MAX_CHARS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  sld_in_if                         char_in,
  sld_out_if                        result,
  input  logic                      cfg_we,
  input  logic [sld_pkg::TGT_W-1:0] cfg_wdata,
  output int                        fail_count,
  output int                        verdicts_pending
);

  localparam int CNT_W = $clog2(MAX_CHARS + 1);

  typedef logic [CNT_W-1:0] tally_t;

  typedef struct packed {
    logic [sld_pkg::LANG_W-1:0] language;
    logic                       target_match;
  } verdict_t;

  tally_t                    kana_n, hangul_n, han_n, cyr_n, latin_n, penalty;
  logic                      in_word;
  tally_t                    word_letters;
  logic [1:0]                word_upper;
  logic                      word_lower, word_mark, word_after_han, prev_han;
  logic [sld_pkg::TGT_W-1:0] target;
  verdict_t                  expected_verdicts[$];
  int                        fails = 0;
  int                        queued = 0;

  assign fail_count       = fails;
  assign verdicts_pending = queued;

  function automatic tally_t sat_inc(tally_t a, int b);
    int s;
    s = int'(a) + b;
    return (s > MAX_CHARS) ? tally_t'(MAX_CHARS) : tally_t'(s);
  endfunction

  function automatic logic in_band(logic [sld_pkg::CP_W-1:0] c, int lo, int hi);
    return (int'(c) >= lo) && (int'(c) <= hi);
  endfunction

  function automatic logic path_or_digit(logic [sld_pkg::CP_W-1:0] c);
    return in_band(c, 'h30, 'h39) || c == 16'h5F || c == 16'h2E || c == 16'h2F ||
           c == 16'h3A || c == 16'h5C || c == 16'h2D;
  endfunction

  function automatic void clear_tallies();
    kana_n = '0; hangul_n = '0; han_n = '0; cyr_n = '0; latin_n = '0; penalty = '0;
    in_word = 1'b0; word_letters = '0; word_upper = '0; word_lower = 1'b0;
    word_mark = 1'b0; word_after_han = 1'b0; prev_han = 1'b0;
  endfunction

  // camel case, code marks or a bordering han char count against latin
  function automatic void close_word(logic han_after);
    logic camel;
    camel = (word_upper >= 2'd2) && word_lower;
    if ((camel || word_mark || word_after_han || han_after) && int'(word_letters) > 2)
      penalty = sat_inc(penalty, int'(word_letters) - 2);
    in_word = 1'b0;
  endfunction

  function automatic void tally_code_unit(logic [sld_pkg::CP_W-1:0] c, logic lst);
    logic     up, lo, letter, han, lone_latin, hit;
    int       evidence, cjk, letters;
    verdict_t v;
    up     = in_band(c, 'h41, 'h5A);
    lo     = in_band(c, 'h61, 'h7A);
    letter = up || lo;
    han    = in_band(c, 'h3400, 'h4DBF) || in_band(c, 'h4E00, 'h9FFF) ||
             in_band(c, 'hF900, 'hFAFF);

    if (letter) begin
      if (!in_word) begin
        in_word        = 1'b1;
        word_letters   = tally_t'(1);
        word_upper     = up ? 2'd1 : 2'd0;
        word_lower     = lo;
        word_mark      = 1'b0;
        word_after_han = prev_han;
      end else begin
        word_letters = sat_inc(word_letters, 1);
        if (up && word_upper < 2'd3) word_upper = word_upper + 2'd1;
        if (lo) word_lower = 1'b1;
      end
    end else if (in_word) begin
      if (path_or_digit(c)) word_mark = 1'b1;
      else close_word(han);
    end
    prev_han = han;

    if (in_band(c, 'h3040, 'h30FF) || in_band(c, 'h31F0, 'h31FF))
      kana_n = sat_inc(kana_n, 1);
    else if (in_band(c, 'hAC00, 'hD7AF) || in_band(c, 'h1100, 'h11FF))
      hangul_n = sat_inc(hangul_n, 1);
    else if (han)
      han_n = sat_inc(han_n, 1);
    else if (in_band(c, 'h0400, 'h04FF))
      cyr_n = sat_inc(cyr_n, 1);
    else if (letter || in_band(c, 'h00C0, 'h024F))
      latin_n = sat_inc(latin_n, 1);

    if (!lst) return;

    if (in_word) close_word(1'b0);
    evidence   = (latin_n > penalty) ? int'(latin_n) - int'(penalty) : 0;
    cjk        = int'(han_n) + int'(kana_n) + int'(hangul_n);
    letters    = cjk + int'(latin_n) + int'(cyr_n);
    lone_latin = (letters == 1) && (latin_n == tally_t'(1));

    if (kana_n != '0 && int'(kana_n) * 12 >= int'(han_n))
      v.language = sld_pkg::LANG_JAPANESE;
    else if (hangul_n != '0)
      v.language = sld_pkg::LANG_KOREAN;
    else if (cyr_n > latin_n && int'(cyr_n) >= 2)
      v.language = sld_pkg::LANG_RUSSIAN;
    else if (int'(han_n) >= 2 && int'(han_n) * 3 >= evidence)
      v.language = sld_pkg::LANG_CHINESE;
    else
      v.language = sld_pkg::LANG_OTHER;

    if (target == sld_pkg::TGT_LATIN) begin
      hit = !(cjk >= 1 && cjk * 2 >= int'(latin_n));
    end else if (letters == 0) begin
      hit = 1'b1;
    end else begin
      case (target)
        sld_pkg::TGT_CHINESE:  hit = han_n != '0 || lone_latin;
        sld_pkg::TGT_JAPANESE: hit = kana_n != '0 || han_n != '0 || lone_latin;
        sld_pkg::TGT_KOREAN:   hit = hangul_n != '0 || lone_latin;
        sld_pkg::TGT_RUSSIAN:  hit = cyr_n != '0 || lone_latin;
        default:               hit = 1'b1;
      endcase
    end
    v.target_match = hit;
    expected_verdicts.push_back(v);
    clear_tallies();
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      clear_tallies();
      target = sld_pkg::TGT_LATIN;
      expected_verdicts.delete();
    end else begin
      if (cfg_we) target = cfg_wdata;
      if (result.valid && result.ready) begin
        if (expected_verdicts.size() == 0) begin
          $error("result beat with no text pending");
          fails++;
        end else begin
          want = expected_verdicts.pop_front();
          if (result.language !== want.language) begin
            $error("language: expected %0d, actual %0d", want.language, result.language);
            fails++;
          end
          if (result.target_match !== want.target_match) begin
            $error("target_match: expected %0d, actual %0d", want.target_match,
                   result.target_match);
            fails++;
          end
        end
      end
      if (char_in.valid && char_in.ready)
        tally_code_unit(char_in.code_point, char_in.last);
    end
    queued = expected_verdicts.size();
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// tb: drives texts and target settings into the script language detector with
// random idling on both channels; sld_script_checker predicts and compares.
// Depends on sld_pkg, sld_in_if, sld_out_if, the detector and the checker.
module tb;

  localparam int MAX_CHARS    = sld_pkg::MAX_CHARS_DEF;
  localparam int CYCLE_LIMIT  = 250000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_UNITS  = 48;
  localparam int TAIL_UNITS   = 16;

  typedef logic [sld_pkg::CP_W-1:0]  cp_t;
  typedef logic [sld_pkg::TGT_W-1:0] tgt_t;

  typedef enum int {
    C_UPPER, C_LOWER, C_MARK, C_PLAIN, C_KANA, C_HANGUL, C_HAN, C_CYR, C_LATX, C_ANY, C_BAND
  } unit_class_t;

  // range limits and their neighbours
  localparam cp_t BAND_LIMITS [56] = '{
    16'h0000, 16'hFFFF, 16'h3040, 16'h303F, 16'h30FF, 16'h3100, 16'h31F0, 16'h31EF,
    16'h31FF, 16'h3200, 16'hAC00, 16'hABFF, 16'hD7AF, 16'hD7B0, 16'h1100, 16'h10FF,
    16'h11FF, 16'h1200, 16'h3400, 16'h33FF, 16'h4DBF, 16'h4DC0, 16'h4E00, 16'h4DFF,
    16'h9FFF, 16'hA000, 16'hF900, 16'hF8FF, 16'hFAFF, 16'hFB00, 16'h0400, 16'h03FF,
    16'h04FF, 16'h0500, 16'h00C0, 16'h00BF, 16'h024F, 16'h0250, 16'h0040, 16'h0041,
    16'h005A, 16'h005B, 16'h0060, 16'h0061, 16'h007A, 16'h007B, 16'h002F, 16'h0030,
    16'h0039, 16'h003A, 16'h003B, 16'h002C, 16'h002D, 16'h002E, 16'h005C, 16'h005F
  };

  // {last, code point}
  localparam logic [sld_pkg::CP_W:0] OPENING_BEATS [26] = '{
    {1'b1, 16'h0041},
    {1'b1, 16'h0000},
    {1'b1, 16'hFFFF},
    {1'b0, 16'h3040}, {1'b0, 16'h4E00}, {1'b1, 16'h31FF},
    {1'b0, 16'h0061}, {1'b0, 16'h0042}, {1'b0, 16'h0063}, {1'b0, 16'h0044},
    {1'b0, 16'h4E00}, {1'b1, 16'h9FFF},
    {1'b0, 16'h3400}, {1'b0, 16'h0041}, {1'b0, 16'h0062}, {1'b0, 16'h0063},
    {1'b0, 16'h002F}, {1'b1, 16'h0031},
    {1'b0, 16'h1100}, {1'b1, 16'hD7AF},
    {1'b0, 16'h0400}, {1'b0, 16'h04FF}, {1'b1, 16'h0061},
    {1'b0, 16'h00C0}, {1'b0, 16'h024F}, {1'b1, 16'hF900}
  };

  localparam unit_class_t SCRIPT_FLAVOURS [7] = '{
    C_KANA, C_HANGUL, C_HAN, C_CYR, C_LATX, C_LOWER, C_UPPER
  };
  localparam unit_class_t LONG_FLAVOURS [5] = '{C_HAN, C_LOWER, C_KANA, C_CYR, C_HANGUL};
  localparam tgt_t LONG_TARGETS [5] = '{
    sld_pkg::TGT_CHINESE, sld_pkg::TGT_LATIN, sld_pkg::TGT_JAPANESE,
    sld_pkg::TGT_RUSSIAN, sld_pkg::TGT_KOREAN
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  tgt_t             cfg_wdata = '0;
  logic             idle_on = 1'b1;
  int               cycles = 0;
  int               fail_count, verdicts_pending;
  cp_t              text_units[$];

  sld_in_if  char_in ();
  sld_out_if result ();

  script_language_detector #(.MAX_CHARS(MAX_CHARS)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .char_in   (char_in),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  sld_script_checker #(.MAX_CHARS(MAX_CHARS)) i_checker (
    .clk              (clk),
    .rst              (rst),
    .char_in          (char_in),
    .result           (result),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .verdicts_pending (verdicts_pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result back-pressure
  initial begin
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        result.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      result.ready <= 1'b1;
    end
  end

  function automatic cp_t draw_unit(unit_class_t cls);
    case (cls)
      C_UPPER: return cp_t'(16'h41 + $urandom_range(0, 25));
      C_LOWER: return cp_t'(16'h61 + $urandom_range(0, 25));
      C_MARK: begin
        case ($urandom_range(0, 6))
          0:       return cp_t'(16'h30 + $urandom_range(0, 9));
          1:       return 16'h005F;
          2:       return 16'h002E;
          3:       return 16'h002F;
          4:       return 16'h003A;
          5:       return 16'h005C;
          default: return 16'h002D;
        endcase
      end
      C_PLAIN: begin
        case ($urandom_range(0, 4))
          0:       return 16'h002C;
          1:       return 16'h0021;
          2:       return 16'h003F;
          3:       return 16'h000A;
          default: return 16'h0020;
        endcase
      end
      C_KANA: begin
        if ($urandom_range(0, 3) == 0) return cp_t'(16'h31F0 + $urandom_range(0, 15));
        return cp_t'(16'h3040 + $urandom_range(0, 'hBF));
      end
      C_HANGUL: begin
        if ($urandom_range(0, 2) == 0) return cp_t'(16'h1100 + $urandom_range(0, 'hFF));
        return cp_t'(16'hAC00 + $urandom_range(0, 'h2BAF));
      end
      C_HAN: begin
        case ($urandom_range(0, 2))
          0:       return cp_t'(16'h3400 + $urandom_range(0, 'h19BF));
          1:       return cp_t'(16'hF900 + $urandom_range(0, 'h1FF));
          default: return cp_t'(16'h4E00 + $urandom_range(0, 'h51FF));
        endcase
      end
      C_CYR:   return cp_t'(16'h0400 + $urandom_range(0, 'hFF));
      C_LATX:  return cp_t'(16'h00C0 + $urandom_range(0, 'h18F));
      C_BAND:  return BAND_LIMITS[$urandom_range(0, 55)];
      default: return cp_t'($urandom_range(0, 'hFFFF));
    endcase
  endfunction

  // ASCII word: lower, capitalised, camel, all caps or code-like
  task automatic push_word();
    int n, style;
    n     = $urandom_range(1, 9);
    style = $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      if (style == 4 && i > 0 && $urandom_range(0, 3) == 0)
        text_units.push_back(draw_unit(C_MARK));
      else if (style == 3 || (style == 2 && (i == 0 || $urandom_range(0, 3) == 0)) ||
               (style == 1 && i == 0))
        text_units.push_back(draw_unit(C_UPPER));
      else
        text_units.push_back(draw_unit(C_LOWER));
    end
  endtask

  task automatic push_run(unit_class_t cls);
    repeat ($urandom_range(1, 5)) begin
      if (cls == C_KANA && $urandom_range(0, 3) == 0) text_units.push_back(draw_unit(C_HAN));
      else text_units.push_back(draw_unit(cls));
    end
  endtask

  task automatic build_text();
    unit_class_t flavour;
    int          pick;
    text_units.delete();
    flavour = SCRIPT_FLAVOURS[$urandom_range(0, 6)];
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 12))
        text_units.push_back(draw_unit(unit_class_t'($urandom_range(0, C_BAND))));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        pick = $urandom_range(0, 9);
        if (pick < 4) push_run(flavour);
        else if (pick < 7) push_word();
        else if (pick < 9) text_units.push_back(draw_unit(C_PLAIN));
        else text_units.push_back(draw_unit(unit_class_t'($urandom_range(0, C_BAND))));
      end
    end
  endtask

  // one dominant script with the odd ASCII word mixed in
  task automatic build_long_text(unit_class_t cls);
    text_units.delete();
    while (text_units.size() < TAIL_UNITS) begin
      if ($urandom_range(0, 15) == 0) push_word();
      else push_run(cls);
    end
  endtask

  task automatic send_char(cp_t cp, logic lst);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      char_in.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    char_in.valid      <= 1'b1;
    char_in.code_point <= cp;
    char_in.last       <= lst;
    do @(posedge clk); while (!char_in.ready);
  endtask

  task automatic send_text();
    foreach (text_units[i]) send_char(text_units[i], i == text_units.size() - 1);
  endtask

  task automatic settle();
    char_in.valid <= 1'b0;
    @(posedge clk);
    while (verdicts_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_target(tgt_t tgt);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= tgt;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int sent;
    char_in.valid      <= 1'b0;
    char_in.code_point <= '0;
    char_in.last       <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (OPENING_BEATS[i])
      send_char(OPENING_BEATS[i][sld_pkg::CP_W-1:0], OPENING_BEATS[i][sld_pkg::CP_W]);

    for (int phase = 0; phase < 12; phase++) begin
      idle_on = (phase != 6);
      write_target((phase < 8) ? tgt_t'(phase) : tgt_t'($urandom_range(0, 7)));
      sent = 0;
      while (sent < PHASE_UNITS) begin
        build_text();
        sent += text_units.size();
        send_text();
      end
    end

    idle_on = 1'b0;
    foreach (LONG_FLAVOURS[i]) begin
      write_target(LONG_TARGETS[i]);
      build_long_text(LONG_FLAVOURS[i]);
      send_text();
    end

    settle();
    if (fail_count == 0 && verdicts_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/sld_pkg.sv
rtl/sld_in_if.sv
rtl/sld_out_if.sv
rtl/script_language_detector.sv
sim/sld_script_checker.sv
sim/tb.sv
